### rtl/display_list_line_sequencer_assert.svh
// Assertion macros for the display-list line sequencer.
// Included by the top level; needs no package.
`ifndef DISPLAY_LIST_LINE_SEQUENCER_ASSERT_SVH
`define DISPLAY_LIST_LINE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlls: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DLLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlls: next-cycle check failed");

`endif

### rtl/dlls_pkg.sv
// Shared types and constants of the display-list line sequencer.
// No dependencies; used by the interfaces and the sequencer module.
`timescale 1ns / 1ps
`default_nettype none

package dlls_pkg;

  localparam int LIST_DEPTH_DEF = 256;
  localparam int WORD_WIDTH_DEF = 16;

  localparam int LINE_W   = 10;
  localparam int ADDR_IN_W = 8;
  localparam int DATA_IN_W = 16;
  localparam int CD_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [LINE_W-1:0] LPF_RESET     = 10'd312;
  localparam logic [CD_W-1:0]   STARTUP_RESET = 8'd60;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] KIND_BROAD = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_BLACK = 2'd2;
  localparam logic [1:0] KIND_VIDEO = 2'd3;

  localparam logic [1:0] OP_BLACK = 2'd0;
  localparam logic [1:0] OP_PAL   = 2'd1;
  localparam logic [1:0] OP_RAW   = 2'd2;
  localparam logic [1:0] OP_WVB   = 2'd3;

  localparam logic [1:0] RENDER_NONE = 2'd0;
  localparam logic [1:0] RENDER_PAL  = 2'd1;
  localparam logic [1:0] RENDER_RAW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LPF     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ILACE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD0  = 3'b010,
    ST_RD1  = 3'b100
  } state_t;

endpackage

`default_nettype wire

### rtl/dlls_in_if.sv
// Request channel of the sequencer: a line-end tick or a list write.
// Depends on dlls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dlls_in_if
  import dlls_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_IN_W-1:0] list_addr;
  logic [DATA_IN_W-1:0] list_data;

  modport source (output valid, cmd, list_addr, list_data, input ready);
  modport sink   (input valid, cmd, list_addr, list_data, output ready);
endinterface

`default_nettype wire

### rtl/dlls_out_if.sv
// Result channel of the sequencer: one line description per tick.
// Depends on dlls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dlls_out_if
  import dlls_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        line_kind;
  logic              buffer_parity;
  logic [1:0]        render_request;
  logic [LINE_W-1:0] current_line;
  logic              blanking_flag;
  logic              frame_start;

  modport source (output valid, line_kind, buffer_parity, render_request, current_line,
                  blanking_flag, frame_start, input ready);
  modport sink   (input valid, line_kind, buffer_parity, render_request, current_line,
                  blanking_flag, frame_start, output ready);
endinterface

`default_nettype wire

### rtl/dlls_cfg_if.sv
// Configuration write channel of the sequencer.
// Depends on dlls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dlls_cfg_if
  import dlls_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/display_list_line_sequencer.sv
// Display-list line sequencer: line counter, field and startup control, list cursor.
// Depends on dlls_pkg, the channel interfaces, dlls_ram and the assertion header.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, list_addr, list_data
//   out_ch   out  valid/ready    line_kind, buffer_parity, render_request,
//                                current_line, blanking_flag, frame_start
//   cfg_ch   in   valid/ready    index, data (ready is always high)
//
// A list write, or a tick that needs no list fetch, completes in the cycle it is accepted.
// A tick that fetches a command from the stored list passes through ST_RD0 and ST_RD1
// for two reads through the single port of the list RAM; no request is taken meanwhile.
// A request is taken only while the output register is empty or its result is taken.
// Reset is synchronous and needs no clearing pass; the list RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "display_list_line_sequencer_assert.svh"

module display_list_line_sequencer
  import dlls_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dlls_in_if.sink   in_ch,
  dlls_out_if.source out_ch,
  dlls_cfg_if.sink  cfg_ch
);

  localparam int ADDR_W = $clog2(LIST_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LIST_DEPTH - 1);

  state_t st_r, st_nxt;

  logic [LINE_W-1:0]     lpf_r;
  logic                  pal_r;
  logic                  ilace_r;

  logic [LINE_W-1:0]     line_r, line_nxt;
  logic                  field_r, field_nxt;
  logic [CD_W-1:0]       cd_r, cd_nxt;
  logic                  user_r, user_nxt;
  logic [ADDR_W-1:0]     cursor_r, cursor_nxt;
  logic [1:0]            act_r, act_nxt;
  logic [WORD_WIDTH-1:0] left_r, left_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic                  par_r, par_nxt;
  logic                  blank_r, blank_nxt;
  logic [WORD_WIDTH-1:0] w0_r;

  logic                  out_valid_r;
  logic [1:0]            o_kind_r;
  logic                  o_par_r;
  logic [1:0]            o_render_r;
  logic [LINE_W-1:0]     o_line_r;
  logic                  o_blank_r;
  logic                  o_wrap_r;

  logic                  in_acc;
  logic                  tick_acc;
  logic                  wr_acc;
  logic                  addr_ok;
  logic [31:0]           addr_ext;
  logic [31:0]           data_ext;
  logic                  is_wrap;
  logic                  is_early;
  logic                  need_fetch;
  logic                  mem_fetch;
  logic                  commit;
  logic [ADDR_W-1:0]     cur1;
  logic [ADDR_W-1:0]     cur2;
  logic [WORD_WIDTH-1:0] w0;
  logic [WORD_WIDTH-1:0] w1;
  logic [1:0]            op_eff;
  logic [WORD_WIDTH-1:0] left_eff;
  logic [1:0]            render;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [WORD_WIDTH-1:0] ram_rdata;

  dlls_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ch.ready  = (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign tick_acc = in_acc && (in_ch.cmd == CMD_TICK);
  assign wr_acc   = in_acc && (in_ch.cmd == CMD_WRITE);

  assign addr_ext  = {{(32 - ADDR_IN_W){1'b0}}, in_ch.list_addr};
  assign data_ext  = {{(32 - DATA_IN_W){1'b0}}, in_ch.list_data};
  assign addr_ok   = addr_ext < 32'(LIST_DEPTH);
  assign ram_we    = wr_acc && addr_ok;
  assign ram_wdata = data_ext[WORD_WIDTH-1:0];

  assign cur1 = (cursor_r == LAST_IDX) ? '0 : cursor_r + 1'b1;
  assign cur2 = (cur1 == LAST_IDX) ? '0 : cur1 + 1'b1;

  always_comb begin
    if (st_r == ST_RD0) begin
      ram_addr = cur1;
    end else if (wr_acc) begin
      ram_addr = addr_ext[ADDR_W-1:0];
    end else begin
      ram_addr = cursor_r;
    end
  end

  assign is_wrap    = line_r >= lpf_r;
  assign is_early   = line_r < LINE_W'(2);
  assign need_fetch = !is_wrap && !is_early && (left_r == '0);
  assign mem_fetch  = need_fetch && user_r;
  assign commit     = (tick_acc && !mem_fetch) || (st_r == ST_RD1);

  always_comb begin
    if (st_r == ST_RD1) begin
      w0 = w0_r;
      w1 = ram_rdata;
    end else begin
      w0 = cursor_r[0] ? '0 : WORD_WIDTH'(OP_WVB);
      w1 = cur1[0] ? '0 : WORD_WIDTH'(OP_WVB);
    end
  end

  always_comb begin
    if (need_fetch) begin
      op_eff   = (w0[WORD_WIDTH-1:2] != '0) ? OP_BLACK : w0[1:0];
      left_eff = w1;
    end else begin
      op_eff   = act_r;
      left_eff = left_r;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    line_nxt   = line_r;
    field_nxt  = field_r;
    cd_nxt     = cd_r;
    user_nxt   = user_r;
    cursor_nxt = cursor_r;
    act_nxt    = act_r;
    left_nxt   = left_r;
    kind_nxt   = kind_r;
    par_nxt    = par_r;
    blank_nxt  = blank_r;
    render     = RENDER_NONE;

    case (st_r)
      ST_IDLE: begin
        if (tick_acc && mem_fetch) begin
          st_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        st_nxt = ST_RD1;
      end
      ST_RD1: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (is_wrap) begin
      blank_nxt  = 1'b1;
      line_nxt   = '0;
      cursor_nxt = '0;
      act_nxt    = OP_BLACK;
      left_nxt   = '0;
      if (ilace_r && field_r) begin
        field_nxt = 1'b0;
      end else begin
        kind_nxt = KIND_BROAD;
        par_nxt  = 1'b0;
        if (ilace_r) begin
          field_nxt = 1'b1;
        end
      end
      if (cd_r != '0) begin
        cd_nxt = cd_r - 1'b1;
        if (cd_r == CD_W'(1)) begin
          user_nxt = 1'b1;
        end
      end else begin
        user_nxt = 1'b1;
      end
    end else if (is_early) begin
      if (!pal_r) begin
        kind_nxt = KIND_BROAD;
        par_nxt  = 1'b0;
      end else if (line_r[0]) begin
        kind_nxt = KIND_SHORT;
        par_nxt  = 1'b0;
      end
      line_nxt = line_r + 1'b1;
    end else begin
      blank_nxt = 1'b0;
      par_nxt   = line_r[0];
      left_nxt  = left_eff;
      act_nxt   = op_eff;
      if (need_fetch) begin
        cursor_nxt = cur2;
      end
      case (op_eff)
        OP_PAL: begin
          kind_nxt = KIND_VIDEO;
          render   = RENDER_PAL;
        end
        OP_RAW: begin
          kind_nxt = KIND_VIDEO;
          render   = RENDER_RAW;
        end
        OP_WVB: begin
          kind_nxt = KIND_BLACK;
          left_nxt = WORD_WIDTH'(2);
        end
        default: begin
          kind_nxt = KIND_BLACK;
        end
      endcase
      if (left_nxt != '0) begin
        left_nxt = left_nxt - 1'b1;
      end
      line_nxt = line_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      lpf_r       <= LPF_RESET;
      pal_r       <= 1'b1;
      ilace_r     <= 1'b1;
      line_r      <= '0;
      field_r     <= 1'b1;
      cd_r        <= STARTUP_RESET;
      user_r      <= 1'b0;
      cursor_r    <= '0;
      act_r       <= OP_BLACK;
      left_r      <= '0;
      kind_r      <= KIND_BROAD;
      par_r       <= 1'b0;
      blank_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (commit) begin
        line_r   <= line_nxt;
        field_r  <= field_nxt;
        cd_r     <= cd_nxt;
        user_r   <= user_nxt;
        cursor_r <= cursor_nxt;
        act_r    <= act_nxt;
        left_r   <= left_nxt;
        kind_r   <= kind_nxt;
        par_r    <= par_nxt;
        blank_r  <= blank_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_LPF:     lpf_r   <= cfg_ch.data[LINE_W-1:0];
          REG_PAL:     pal_r   <= cfg_ch.data[0];
          REG_ILACE:   ilace_r <= cfg_ch.data[0];
          REG_STARTUP: cd_r    <= cfg_ch.data[CD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RD0) begin
      w0_r <= ram_rdata;
    end
    if (commit) begin
      o_kind_r   <= kind_nxt;
      o_par_r    <= par_nxt;
      o_render_r <= render;
      o_line_r   <= line_r;
      o_blank_r  <= blank_nxt;
      o_wrap_r   <= is_wrap;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_kind      = o_kind_r;
  assign out_ch.buffer_parity  = o_par_r;
  assign out_ch.render_request = o_render_r;
  assign out_ch.current_line   = o_line_r;
  assign out_ch.blanking_flag  = o_blank_r;
  assign out_ch.frame_start    = o_wrap_r;

  `DLLS_ASSERT_SAME(a_busy_no_ready, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `DLLS_ASSERT_SAME(a_busy_slot_free, clk, rst_n, st_r != ST_IDLE, !out_valid_r)
  `DLLS_ASSERT_NEXT(a_rd0_then_rd1, clk, rst_n, st_r == ST_RD0, st_r == ST_RD1)
  `DLLS_ASSERT_SAME(a_wrap_blanks, clk, rst_n, out_valid_r && o_wrap_r,
                    o_blank_r && (o_render_r == RENDER_NONE))

endmodule

`default_nettype wire

### rtl/dlls_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dlls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
